// ----- sv/khct_pkg.sv -----
// ----------------------------------------------------------------------------
// khct_pkg
// Shared field widths, opcodes, result kinds and control types for the
// keyed hit counter table.
// ----------------------------------------------------------------------------
`default_nettype none

package khct_pkg;

  localparam int OPCODE_W = 1;
  localparam int KEY_W    = 32;
  localparam int COUNT_W  = 32;
  localparam int KIND_W   = 2;

  localparam logic [OPCODE_W-1:0] OP_RECORD = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_DRAIN  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_HIT     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DRAINED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd2;

  localparam logic [COUNT_W-1:0] NEW_COUNT = 32'd1;

  // Access strobes from the sequencer to the entry store
  typedef struct packed {
    logic rd_en;
    logic key_we;
    logic count_we;
  } khct_mem_ctl_t;

endpackage : khct_pkg

`default_nettype wire

// ----- sv/khct_in_if.sv -----
// ----------------------------------------------------------------------------
// khct_in_if
// Request channel: valid/ready handshake with opcode and file key.
// ----------------------------------------------------------------------------
`default_nettype none

interface khct_in_if;
  import khct_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [KEY_W-1:0]    file_key;

  modport source (output valid, output opcode, output file_key, input ready);
  modport sink   (input valid, input opcode, input file_key, output ready);

endinterface : khct_in_if

`default_nettype wire

// ----- sv/khct_out_if.sv -----
// ----------------------------------------------------------------------------
// khct_out_if
// Result channel: valid/ready handshake with table results; a record item yields one, a drain one per entry.
// ----------------------------------------------------------------------------
`default_nettype none

interface khct_out_if;
  import khct_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [KEY_W-1:0]   entry_key;
  logic [COUNT_W-1:0] hit_count;
  logic               newly_added;
  logic               dropped;
  logic               last;

  modport source (output valid, output kind, output entry_key, output hit_count,
                  output newly_added, output dropped, output last, input ready);
  modport sink   (input valid, input kind, input entry_key, input hit_count,
                  input newly_added, input dropped, input last, output ready);

endinterface : khct_out_if

`default_nettype wire

// ----- sv/khct_table.sv -----
// ----------------------------------------------------------------------------
// khct_table
// Entry store: key and count arrays, one write address and one registered
// read per cycle. Read data holds when no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module khct_table #(
  parameter int DEPTH  = 32,
  parameter int SKEY_W = 32,
  parameter int IDX_W  = 5
) (
  input  wire                         clk,
  input  khct_pkg::khct_mem_ctl_t     ctl,
  input  wire [IDX_W-1:0]             rd_addr,
  input  wire [IDX_W-1:0]             wr_addr,
  input  wire [SKEY_W-1:0]            wr_key,
  input  wire [khct_pkg::COUNT_W-1:0] wr_count,
  output logic [SKEY_W-1:0]           rd_key,
  output logic [khct_pkg::COUNT_W-1:0] rd_count
);
  import khct_pkg::*;

  logic [SKEY_W-1:0]  key_mem   [DEPTH];
  logic [COUNT_W-1:0] count_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (ctl.count_we) begin
      count_mem[wr_addr] <= wr_count;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_key   <= key_mem[rd_addr];
      rd_count <= count_mem[rd_addr];
    end
  end

endmodule : khct_table

`default_nettype wire

// ----- sv/keyed_hit_counter_table.sv -----
// ----------------------------------------------------------------------------
// keyed_hit_counter_table
// Counts hits per file key in a table kept in insertion order; a drain item
// streams out every entry and empties the table.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake        | payload
//  in_ch    | in  | valid/ready      | opcode, file_key
//  out_ch   | out | valid/ready      | kind, entry_key, hit_count,
//           |     |                  | newly_added, dropped, last
//
//  A record item scans the stored entries one per cycle through the single
//  registered read port and one key comparator; its result passes through
//  the result register into the output register.
//  A drain item reads one entry per cycle and emits one result per cycle
//  while the output is taken. Reset clears the entry count and control only;
//  the store itself is never cleared. A stalled output holds the drain and
//  the final result; the next item is taken while the last result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_hit_counter_table #(
  parameter int TABLE_ENTRIES = 32,
  parameter int KEY_BITS      = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  khct_in_if.sink     in_ch,
  khct_out_if.source  out_ch
);
  import khct_pkg::*;

  localparam int SKEY_W = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]        state_r,   state_nxt;
  logic [CNT_W-1:0]  used_r,    used_nxt;
  logic [CNT_W-1:0]  rd_idx_r,  rd_idx_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic              pend_r,    pend_nxt;
  logic [SKEY_W-1:0] key_r,     key_nxt;

  logic [KIND_W-1:0]  res_kind_r,  res_kind_nxt;
  logic [KEY_W-1:0]   res_key_r,   res_key_nxt;
  logic [COUNT_W-1:0] res_count_r, res_count_nxt;
  logic               res_added_r, res_added_nxt;
  logic               res_drop_r,  res_drop_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]  out_kind_r,  out_kind_nxt;
  logic [KEY_W-1:0]   out_key_r,   out_key_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic               out_added_r, out_added_nxt;
  logic               out_drop_r,  out_drop_nxt;
  logic               out_last_r,  out_last_nxt;

  khct_mem_ctl_t      mem_ctl;
  logic [IDX_W-1:0]   wr_addr;
  logic [SKEY_W-1:0]  rd_key;
  logic [COUNT_W-1:0] rd_count;
  logic [COUNT_W-1:0] wr_count;

  logic in_acc;
  logic out_free;
  logic key_hit;
  logic at_end;
  logic tbl_full;
  logic drain_last;
  logic out_load;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign key_hit     = pend_r && (rd_key == key_r);
  assign at_end      = (rd_idx_r == used_r);
  assign tbl_full    = (used_r == CNT_W'(TABLE_ENTRIES));
  assign drain_last  = ((CNT_W'(cmp_idx_r) + CNT_W'(1)) == used_r);

  khct_table #(
    .DEPTH  (TABLE_ENTRIES),
    .SKEY_W (SKEY_W),
    .IDX_W  (IDX_W)
  ) u_table (
    .clk      (clk),
    .ctl      (mem_ctl),
    .rd_addr  (rd_idx_r[IDX_W-1:0]),
    .wr_addr  (wr_addr),
    .wr_key   (key_r),
    .wr_count (wr_count),
    .rd_key   (rd_key),
    .rd_count (rd_count)
  );

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    pend_nxt      = pend_r;
    key_nxt       = key_r;
    res_kind_nxt  = res_kind_r;
    res_key_nxt   = res_key_r;
    res_count_nxt = res_count_r;
    res_added_nxt = res_added_r;
    res_drop_nxt  = res_drop_r;
    out_kind_nxt  = out_kind_r;
    out_key_nxt   = out_key_r;
    out_count_nxt = out_count_r;
    out_added_nxt = out_added_r;
    out_drop_nxt  = out_drop_r;
    out_last_nxt  = out_last_r;
    out_load      = 1'b0;
    mem_ctl       = '0;
    wr_addr       = used_r[IDX_W-1:0];
    wr_count      = NEW_COUNT;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          key_nxt    = in_ch.file_key[SKEY_W-1:0];
          rd_idx_nxt = '0;
          pend_nxt   = 1'b0;
          if (in_ch.opcode == OP_DRAIN) begin
            if (used_r == '0) begin
              res_kind_nxt  = KIND_EMPTY;
              res_key_nxt   = '0;
              res_count_nxt = '0;
              res_added_nxt = 1'b0;
              res_drop_nxt  = 1'b0;
              state_nxt     = ST_EMIT;
            end else begin
              state_nxt = ST_DRAIN;
            end
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        res_kind_nxt = KIND_HIT;
        res_key_nxt  = KEY_W'(key_r);
        if (key_hit) begin
          // saturate at all ones
          wr_addr          = cmp_idx_r;
          wr_count         = (&rd_count) ? rd_count : rd_count + COUNT_W'(1);
          mem_ctl.count_we = 1'b1;
          res_count_nxt    = wr_count;
          res_added_nxt    = 1'b0;
          res_drop_nxt     = 1'b0;
          state_nxt        = ST_EMIT;
        end else if (at_end) begin
          if (tbl_full) begin
            res_count_nxt = '0;
            res_added_nxt = 1'b0;
            res_drop_nxt  = 1'b1;
          end else begin
            mem_ctl.key_we   = 1'b1;
            mem_ctl.count_we = 1'b1;
            used_nxt         = used_r + CNT_W'(1);
            res_count_nxt    = NEW_COUNT;
            res_added_nxt    = 1'b1;
            res_drop_nxt     = 1'b0;
          end
          state_nxt = ST_EMIT;
        end else begin
          mem_ctl.rd_en = 1'b1;
          cmp_idx_nxt   = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt    = rd_idx_r + CNT_W'(1);
          pend_nxt      = 1'b1;
        end
      end

      ST_DRAIN: begin
        if (pend_r && out_free) begin
          out_load      = 1'b1;
          out_kind_nxt  = KIND_DRAINED;
          out_key_nxt   = KEY_W'(rd_key);
          out_count_nxt = rd_count;
          out_added_nxt = 1'b0;
          out_drop_nxt  = 1'b0;
          out_last_nxt  = drain_last;
          pend_nxt      = 1'b0;
          if (drain_last) begin
            used_nxt  = '0;
            state_nxt = ST_IDLE;
          end
        end
        // fetch the next entry once the held one is free to go
        if ((!pend_r || out_free) && !at_end) begin
          mem_ctl.rd_en = 1'b1;
          cmp_idx_nxt   = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt    = rd_idx_r + CNT_W'(1);
          pend_nxt      = 1'b1;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_key_nxt   = res_key_r;
          out_count_nxt = res_count_r;
          out_added_nxt = res_added_r;
          out_drop_nxt  = res_drop_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    key_r       <= key_nxt;
    res_kind_r  <= res_kind_nxt;
    res_key_r   <= res_key_nxt;
    res_count_r <= res_count_nxt;
    res_added_r <= res_added_nxt;
    res_drop_r  <= res_drop_nxt;
    out_kind_r  <= out_kind_nxt;
    out_key_r   <= out_key_nxt;
    out_count_r <= out_count_nxt;
    out_added_r <= out_added_nxt;
    out_drop_r  <= out_drop_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_kind_r;
  assign out_ch.entry_key   = out_key_r;
  assign out_ch.hit_count   = out_count_r;
  assign out_ch.newly_added = out_added_r;
  assign out_ch.dropped     = out_drop_r;
  assign out_ch.last        = out_last_r;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count exceeds table size");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.rd_en |-> (rd_idx_r < used_r))
    else $error("read issued beyond stored entries");

  a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN && out_load && drain_last) |=> (used_r == '0))
    else $error("table not emptied after final drained entry");

  a_added_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_added_r && out_drop_r))
    else $error("result both added and dropped");
`endif

endmodule : keyed_hit_counter_table

`default_nettype wire

// ----- bench/tb_keyed_hit_counter_table.sv -----
// ----------------------------------------------------------------------------
// tb_keyed_hit_counter_table
// Self-checking bench for the keyed hit counter table. A queue of record and
// drain items feeds a clocked driver. A shadow copy of the table predicts
// every report. A clocked monitor compares each report taken from the block
// with the oldest prediction. Four phases vary sender gaps and receiver
// stalls. The table is filled past capacity to exercise dropped keys.
// ----------------------------------------------------------------------------
module tb_keyed_hit_counter_table;
  import khct_pkg::*;

  localparam int ENTRIES      = 32;
  localparam int ITEMS_PER_PH = 64;
  localparam int SETTLE_CYC   = 40;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [KEY_W-1:0]    file_key;
  } request_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [KEY_W-1:0]   entry_key;
    logic [COUNT_W-1:0] hit_count;
    logic               newly_added;
    logic               dropped;
    logic               last;
  } report_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                src_valid  = 1'b0;
  logic [OPCODE_W-1:0] src_opcode = OP_RECORD;
  logic [KEY_W-1:0]    src_key    = '0;
  logic                sink_ready = 1'b0;

  int sender_idle_pct = 0;
  int sink_stall_pct  = 0;
  int mismatches      = 0;
  int items_queued    = 0;

  request_t requests_waiting[$];
  report_t  reports_due[$];

  // Shadow of the block's table
  logic [KEY_W-1:0]   shadow_keys[ENTRIES];
  logic [COUNT_W-1:0] shadow_counts[ENTRIES];
  int                 shadow_used = 0;

  khct_in_if  in_ch ();
  khct_out_if out_ch ();

  assign in_ch.valid    = src_valid;
  assign in_ch.opcode   = src_opcode;
  assign in_ch.file_key = src_key;
  assign out_ch.ready   = sink_ready;

  keyed_hit_counter_table #(
    .TABLE_ENTRIES(ENTRIES),
    .KEY_BITS     (KEY_W)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic void push_report(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                                      logic [COUNT_W-1:0] count, logic added,
                                      logic drop, logic fin);
    report_t r;
    r.kind        = kind;
    r.entry_key   = key;
    r.hit_count   = count;
    r.newly_added = added;
    r.dropped     = drop;
    r.last        = fin;
    reports_due.push_back(r);
  endfunction

  // Apply one accepted item to the shadow table and queue its reports
  function automatic void tally_request(request_t rq);
    int slot;
    slot = -1;
    if (rq.opcode == OP_RECORD) begin
      for (int i = 0; i < shadow_used; i++) begin
        if (slot < 0 && shadow_keys[i] == rq.file_key) slot = i;
      end
      if (slot >= 0) begin
        if (shadow_counts[slot] != '1) shadow_counts[slot] = shadow_counts[slot] + 1'b1;
        push_report(KIND_HIT, rq.file_key, shadow_counts[slot], 1'b0, 1'b0, 1'b1);
      end else if (shadow_used >= ENTRIES) begin
        push_report(KIND_HIT, rq.file_key, '0, 1'b0, 1'b1, 1'b1);
      end else begin
        shadow_keys[shadow_used]   = rq.file_key;
        shadow_counts[shadow_used] = NEW_COUNT;
        shadow_used++;
        push_report(KIND_HIT, rq.file_key, NEW_COUNT, 1'b1, 1'b0, 1'b1);
      end
    end else if (shadow_used == 0) begin
      push_report(KIND_EMPTY, '0, '0, 1'b0, 1'b0, 1'b1);
    end else begin
      for (int i = 0; i < shadow_used; i++)
        push_report(KIND_DRAINED, shadow_keys[i], shadow_counts[i], 1'b0, 1'b0,
                    i == shadow_used - 1);
      shadow_used = 0;
    end
  endfunction

  always @(posedge clk) begin : drive_requests
    logic take_next;
    request_t sent;
    if (!rst_n) begin
      src_valid <= 1'b0;
    end else begin
      take_next = !src_valid;
      if (src_valid && in_ch.ready) begin
        sent.opcode   = src_opcode;
        sent.file_key = src_key;
        tally_request(sent);
        void'(requests_waiting.pop_front());
        take_next = 1'b1;
      end
      if (take_next) begin
        if (requests_waiting.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          src_valid  <= 1'b1;
          src_opcode <= requests_waiting[0].opcode;
          src_key    <= requests_waiting[0].file_key;
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_reports
    report_t seen;
    report_t want;
    if (!rst_n) begin
      sink_ready <= 1'b0;
    end else begin
      if (out_ch.valid && sink_ready) begin
        seen.kind        = out_ch.kind;
        seen.entry_key   = out_ch.entry_key;
        seen.hit_count   = out_ch.hit_count;
        seen.newly_added = out_ch.newly_added;
        seen.dropped     = out_ch.dropped;
        seen.last        = out_ch.last;
        if (reports_due.size() == 0) begin
          $display("%0t: unexpected report kind %0d key %h count %h added %b drop %b last %b",
                   $time, seen.kind, seen.entry_key, seen.hit_count, seen.newly_added,
                   seen.dropped, seen.last);
          mismatches++;
        end else begin
          want = reports_due.pop_front();
          if (seen !== want) begin
            $display("%0t: mismatch expected kind %0d key %h count %h added %b drop %b last %b",
                     $time, want.kind, want.entry_key, want.hit_count, want.newly_added,
                     want.dropped, want.last);
            $display("%0t:          actual   kind %0d key %h count %h added %b drop %b last %b",
                     $time, seen.kind, seen.entry_key, seen.hit_count, seen.newly_added,
                     seen.dropped, seen.last);
            mismatches++;
          end
        end
      end
      sink_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  task automatic queue_record(logic [KEY_W-1:0] key);
    request_t rq;
    rq.opcode   = OP_RECORD;
    rq.file_key = key;
    requests_waiting.push_back(rq);
    items_queued++;
  endtask

  task automatic queue_drain();
    request_t rq;
    rq.opcode   = OP_DRAIN;
    rq.file_key = $urandom();
    requests_waiting.push_back(rq);
    items_queued++;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic wait_drained();
    while (requests_waiting.size() != 0 || reports_due.size() != 0) @(negedge clk);
  endtask

  // Empty and fill the table, hit stored keys, push new keys into the full table, hit again, drain
  task automatic fill_past_capacity();
    logic [KEY_W-1:0] keys[ENTRIES];
    queue_drain();
    for (int i = 0; i < ENTRIES; i++) begin
      keys[i] = $urandom();
      queue_record(keys[i]);
    end
    for (int i = 0; i < 4; i++) queue_record(keys[$urandom_range(0, ENTRIES - 1)]);
    for (int i = 0; i < 3; i++) queue_record(pick_key());
    queue_record(keys[ENTRIES - 1]);
    queue_drain();
  endtask

  task automatic queue_random(int budget);
    logic [KEY_W-1:0] pool[36];
    int stop_at;
    int pool_n;
    int hits;
    int shape;
    stop_at = items_queued + budget;
    while (items_queued < stop_at) begin
      shape = $urandom_range(0, 99);
      if (shape < 65) begin
        // well-formed burst: records over a small key pool, then drain
        pool_n = $urandom_range(1, 36);
        for (int i = 0; i < pool_n; i++) pool[i] = pick_key();
        hits = $urandom_range(pool_n, 2 * pool_n + 4);
        for (int i = 0; i < hits; i++) queue_record(pool[$urandom_range(0, pool_n - 1)]);
        queue_drain();
      end else if (shape < 72) begin
        fill_past_capacity();
      end else begin
        // noise: stray records and drains
        for (int i = $urandom_range(1, 5); i > 0; i--) begin
          if ($urandom_range(0, 3) == 0) queue_drain();
          else queue_record(pick_key());
        end
      end
    end
  endtask

  initial begin : run_phases
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin sender_idle_pct = 57; sink_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  sink_stall_pct = 57; end
        default: begin sender_idle_pct = 25; sink_stall_pct = 25; end
      endcase
      if (ph == 0) begin
        // empty drain, key extremes, repeat hits, single-entry drain
        queue_drain();
        queue_record('0);
        queue_record('1);
        queue_record('0);
        queue_record(32'hAAAA_AAAA);
        queue_record(32'h5555_5555);
        queue_record('1);
        queue_drain();
        queue_drain();
        queue_record(32'h0000_0001);
        queue_drain();
        // a saturated count needs 2^32 - 1 hits and is out of reach here
        fill_past_capacity();
      end
      queue_random(ITEMS_PER_PH);
      // hold the sender until every report of this phase is back
      wait_drained();
    end
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/khct_pkg.sv
sv/khct_in_if.sv
sv/khct_out_if.sv
sv/khct_table.sv
sv/keyed_hit_counter_table.sv
bench/tb_keyed_hit_counter_table.sv
